// File: src/rte_pkg.sv
// Shared types, constants and helpers for the run-length text row encoder.
package rte_pkg;

  localparam int unsigned MaxRunDefault = 1024;
  // Run lengths are kept as BCD; 4 digits cover MAX_RUN up to 9999.
  localparam int unsigned RunDigits = 4;
  localparam int unsigned LenW      = 4 * RunDigits;

  localparam logic [7:0] SepChar   = 8'h7C;
  localparam logic [7:0] DigitBase = 8'h30;

  // Output slot order for one burst: closed run digits, closed run byte,
  // tail run digits, tail run byte, row separator.
  localparam int unsigned SlotCloseDig  = 0;
  localparam int unsigned SlotCloseByte = SlotCloseDig + RunDigits;
  localparam int unsigned SlotTailDig   = SlotCloseByte + 1;
  localparam int unsigned SlotTailByte  = SlotTailDig + RunDigits;
  localparam int unsigned SlotSep       = SlotTailByte + 1;
  localparam int unsigned NumSlots      = SlotSep + 1;

  typedef logic [LenW-1:0] len_bcd_t;

  typedef struct packed {
    logic       close_v;
    logic [7:0] close_byte;
    len_bcd_t   close_len;
    logic       tail_v;
    logic [7:0] tail_byte;
    len_bcd_t   tail_len;
    logic       sep;
  } burst_t;

  function automatic len_bcd_t bcd_inc(input len_bcd_t v);
    len_bcd_t   r;
    logic       c;
    logic [3:0] d;
    r = v;
    c = 1'b1;
    for (int i = 0; i < RunDigits; i++) begin
      d = v[4*i +: 4];
      if (c) begin
        if (d == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = d + 4'd1;
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Bit i set when the i-th digit (most significant first) is printed.
  function automatic logic [RunDigits-1:0] digit_mask(input len_bcd_t v);
    logic [RunDigits-1:0] m;
    logic                 seen;
    logic                 multi;
    m     = '0;
    seen  = 1'b0;
    multi = (v != len_bcd_t'(1));
    for (int i = 0; i < RunDigits; i++) begin
      seen = seen | (v[LenW-1-4*i -: 4] != 4'd0);
      m[i] = seen & multi;
    end
    return m;
  endfunction

  function automatic logic [7:0] digit_char(input len_bcd_t v, input int unsigned i);
    return DigitBase | {4'h0, v[LenW-1-4*i -: 4]};
  endfunction

endpackage

// File: src/rte_if.sv
// Valid/ready channel interfaces for cells in and text bytes out.
interface rte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_req;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, output cell_req, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input cell_req, input row_end, input frame_end,
                  output ready);
endinterface

interface rte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// File: src/rle_text_row_encoder_top.sv
// Top level of the run-length text row encoder.
//
//   channel  dir  payload                 transfer when
//   in_i     in   cell_req row_end frame  valid && ready
//   out_o    out  out_char last           valid && ready
//
// One cell is taken per cycle while no burst is pending; cells that only
// extend or open a run give no output. A cell that closes runs hands a
// burst of 1 to 7 characters to the serializer, which sends one character
// per cycle while out_o is ready; the input holds while a burst waits for
// the previous one to drain. The cell, its burst (serializer slots) and its
// first character (output register) are registered in turn; a draining burst
// or a stalled output delays it. Reset clears the open run and all valid flags.
module rle_text_row_encoder_top #(
  parameter int unsigned MaxRun = rte_pkg::MaxRunDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rte_in_if.sink     in_i,
  rte_out_if.source  out_o
);

  logic            rec_valid;
  logic            rec_ready;
  rte_pkg::burst_t rec;

  rte_run #(
    .MaxRun (MaxRun)
  ) u_run (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .cell_i      (in_i.cell_req),
    .row_end_i   (in_i.row_end),
    .frame_end_i (in_i.frame_end),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  rte_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_ready_o (rec_ready),
    .rec_i       (rec),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .out_last_o  (out_o.last)
  );

  a_burst_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid |-> (rec.close_v || rec.tail_v))
    else $error("burst with no run");

  a_sep_with_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && rec.sep |-> rec.tail_v)
    else $error("separator without row end run");

  a_run_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid |-> (!rec.close_v || rec.close_len != '0) && (!rec.tail_v || rec.tail_len != '0))
    else $error("zero length run in burst");

  a_hold_on_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec))
    else $error("pending burst changed before transfer");

endmodule

// File: src/rte_run.sv
// Input register and open-run tracking; hands closed runs to the serializer as bursts.
module rte_run #(
  parameter int unsigned MaxRun = rte_pkg::MaxRunDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      cell_i,
  input  logic            row_end_i,
  input  logic            frame_end_i,
  output logic            rec_valid_o,
  input  logic            rec_ready_i,
  output rte_pkg::burst_t rec_o
);

  localparam rte_pkg::len_bcd_t MaxBcd = {
    4'((MaxRun / 1000) % 10), 4'((MaxRun / 100) % 10),
    4'((MaxRun / 10) % 10),   4'(MaxRun % 10)
  };

  logic              v_q;
  logic [7:0]        cell_q;
  logic              row_end_q;
  logic              frame_end_q;
  logic              open_q;
  logic [7:0]        byte_q;
  rte_pkg::len_bcd_t len_q;

  logic              same;
  logic              close;
  logic              burst;
  logic              adv;
  rte_pkg::len_bcd_t new_len;

  assign same    = open_q && (cell_q == byte_q) && (len_q != MaxBcd);
  assign close   = open_q && !same;
  assign new_len = same ? rte_pkg::bcd_inc(len_q) : rte_pkg::len_bcd_t'(1);
  assign burst   = close || row_end_q;
  assign adv     = v_q && (!burst || rec_ready_i);

  assign in_ready_o  = !v_q || adv;
  assign rec_valid_o = v_q && burst;

  always_comb begin
    rec_o            = '0;
    rec_o.close_v    = close;
    rec_o.close_byte = byte_q;
    rec_o.close_len  = len_q;
    rec_o.tail_v     = row_end_q;
    rec_o.tail_byte  = cell_q;
    rec_o.tail_len   = new_len;
    rec_o.sep        = row_end_q && !frame_end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      open_q <= 1'b0;
      byte_q <= '0;
      len_q  <= '0;
    end else begin
      if (in_ready_o) begin
        v_q <= in_valid_i;
      end
      if (adv) begin
        if (row_end_q) begin
          open_q <= 1'b0;
          byte_q <= '0;
          len_q  <= '0;
        end else begin
          open_q <= 1'b1;
          byte_q <= cell_q;
          len_q  <= new_len;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cell_q      <= cell_i;
      row_end_q   <= row_end_i;
      frame_end_q <= frame_end_i;
    end
  end

endmodule

// File: src/rte_ser.sv
// Burst serializer: walks the pending character slots into a registered output.
module rte_ser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rec_valid_i,
  output logic            rec_ready_o,
  input  rte_pkg::burst_t rec_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);

  localparam int unsigned NS = rte_pkg::NumSlots;
  localparam int unsigned ND = rte_pkg::RunDigits;

  rte_pkg::burst_t rec_q;
  logic [NS-1:0]   mask_q;
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;

  logic [NS-1:0]   new_mask;
  logic [NS-1:0]   pick;
  logic [NS-1:0]   rest;
  logic [7:0]      slot_char [NS];
  logic [7:0]      sel_char;
  logic            load_out;
  logic            emit;

  always_comb begin
    new_mask = '0;
    if (rec_i.close_v) begin
      new_mask[rte_pkg::SlotCloseDig +: ND] = rte_pkg::digit_mask(rec_i.close_len);
      new_mask[rte_pkg::SlotCloseByte]      = 1'b1;
    end
    if (rec_i.tail_v) begin
      new_mask[rte_pkg::SlotTailDig +: ND] = rte_pkg::digit_mask(rec_i.tail_len);
      new_mask[rte_pkg::SlotTailByte]      = 1'b1;
    end
    new_mask[rte_pkg::SlotSep] = rec_i.sep;
  end

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      slot_char[rte_pkg::SlotCloseDig + i] = rte_pkg::digit_char(rec_q.close_len, i);
      slot_char[rte_pkg::SlotTailDig + i]  = rte_pkg::digit_char(rec_q.tail_len, i);
    end
    slot_char[rte_pkg::SlotCloseByte] = rec_q.close_byte;
    slot_char[rte_pkg::SlotTailByte]  = rec_q.tail_byte;
    slot_char[rte_pkg::SlotSep]       = rte_pkg::SepChar;
  end

  // lowest pending slot goes first
  assign pick = mask_q & (~mask_q + NS'(1));
  assign rest = mask_q & ~pick;

  always_comb begin
    sel_char = '0;
    for (int i = 0; i < NS; i++) begin
      sel_char = sel_char | (slot_char[i] & {8{pick[i]}});
    end
  end

  assign load_out    = !out_valid_q || out_ready_i;
  assign emit        = load_out && (mask_q != '0);
  assign rec_ready_o = (mask_q == '0) || (emit && (rest == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rec_valid_i && rec_ready_o) begin
        mask_q <= new_mask;
      end else if (emit) begin
        mask_q <= rest;
      end
      if (load_out) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_valid_i && rec_ready_o) begin
      rec_q <= rec_i;
    end
    if (emit) begin
      out_char_q <= sel_char;
      out_last_q <= (rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// File: tb/rte_text_checker.sv
// Checker: predicts the encoded text from accepted cells and compares it with the output.
module rte_text_checker #(
  parameter int unsigned MaxRun = rte_pkg::MaxRunDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  rte_in_if    in_mon,
  rte_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  text_byte_t  text_q[$];
  logic [7:0]  burst[$];
  bit          run_open = 1'b0;
  logic [7:0]  run_byte = '0;
  int unsigned run_len  = 0;
  int          mismatches = 0;

  // Decimal count (only above one), then the run byte.
  function automatic void add_run();
    int unsigned v;
    logic [7:0]  dig[$];
    v = run_len;
    if (v > 1) begin
      while (v > 0) begin
        dig.push_front(rte_pkg::DigitBase + 8'(v % 10));
        v = v / 10;
      end
    end
    foreach (dig[i]) burst = {burst, dig[i]};
    burst = {burst, run_byte};
  endfunction

  function automatic void encode_cell(input logic [7:0] c, input logic re, input logic fe);
    text_byte_t tb_item;
    burst.delete();
    if (!run_open) begin
      run_open = 1'b1;
      run_byte = c;
      run_len  = 1;
    end else if (c == run_byte && run_len < MaxRun) begin
      run_len++;
    end else begin
      add_run();
      run_byte = c;
      run_len  = 1;
    end
    if (re) begin
      add_run();
      run_open = 1'b0;
      run_byte = '0;
      run_len  = 0;
      if (!fe) burst = {burst, rte_pkg::SepChar};
    end
    foreach (burst[i]) begin
      tb_item.ch   = burst[i];
      tb_item.last = (i == burst.size() - 1);
      text_q = {text_q, tb_item};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_byte_t want;
    if (!rst_ni) begin
      run_open = 1'b0;
      run_byte = '0;
      run_len  = 0;
      text_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected char %h last %b", $realtime, out_mon.out_char,
                     out_mon.last);
        end else begin
          want = text_q.pop_front();
          if (out_mon.out_char !== want.ch || out_mon.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: char exp %h got %h, last exp %b got %b", $realtime,
                       want.ch, out_mon.out_char, want.last, out_mon.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        encode_cell(in_mon.cell_req, in_mon.row_end, in_mon.frame_end);
    end
    fail_count_o <= mismatches;
    pending_o    <= text_q.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top: drives cell rows into the encoder, paces the text output, gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxRun     = rte_pkg::MaxRunDefault;
  localparam int          CycleLimit = 400000;
  localparam int          RandCells  = 240;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   idle_on = 1'b1;
  bit   hold_go = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  rte_in_if  in_ch ();
  rte_out_if out_ch ();

  rle_text_row_encoder_top #(.MaxRun(MaxRun)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rte_text_checker #(.MaxRun(MaxRun)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output pacing; a hold request stalls the receiver for a long stretch.
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 35);
      end
    end
  end

  task automatic send_cell(input logic [7:0] c, input logic re, input logic fe);
    while (idle_on && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cell_req  <= c;
    in_ch.row_end   <= re;
    in_ch.frame_end <= fe;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // n equal cells; row flags go on the last one only
  task automatic send_run(input logic [7:0] c, input int n, input logic re, input logic fe);
    for (int i = 0; i < n - 1; i++) send_cell(c, 1'b0, 1'b0);
    send_cell(c, re, fe);
  endtask

  initial begin
    int         sent;
    int         runs;
    int         len;
    logic [7:0] c;
    bit         held;
    in_ch.valid     = 1'b0;
    in_ch.cell_req  = '0;
    in_ch.row_end   = 1'b0;
    in_ch.frame_end = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, one-cell rows, last row, ignored frame flag
    send_cell(8'h00, 1'b1, 1'b0);
    send_cell(8'hFF, 1'b1, 1'b1);
    send_run(8'h41, 2, 1'b1, 1'b0);
    send_cell(8'h42, 1'b0, 1'b1);
    send_cell(8'h42, 1'b0, 1'b0);
    send_cell(8'h43, 1'b1, 1'b1);
    send_run(rte_pkg::SepChar, 10, 1'b1, 1'b0);
    send_cell(8'h30, 1'b0, 1'b0);
    send_cell(8'h31, 1'b0, 1'b0);
    send_cell(8'h31, 1'b1, 1'b0);
    send_cell(8'h80, 1'b0, 1'b0);
    send_cell(8'h7F, 1'b0, 1'b0);
    send_cell(8'h7F, 1'b1, 1'b1);

    // three-digit run closed by a one-cell row end: longest burst here
    idle_on = 1'b0;
    send_run(8'hAA, 100, 1'b0, 1'b0);
    send_cell(8'h42, 1'b1, 1'b0);
    idle_on = 1'b1;

    // random rows built from runs
    sent = 0;
    held = 1'b0;
    while (sent < RandCells) begin
      if (!held && sent >= 60) begin
        held    = 1'b1;
        hold_go = 1'b1;
      end
      idle_on = !(sent >= 150 && sent < 200);
      runs = $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
        if ($urandom_range(9) < 7) c = 8'h2E + 8'($urandom_range(3));
        else c = 8'($urandom_range(255));
        if ($urandom_range(19) == 0) len = $urandom_range(10, 60);
        else len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          if (r == runs - 1 && k == len - 1)
            send_cell(c, 1'b1, $urandom_range(4) == 0);
          else
            send_cell(c, 1'b0, $urandom_range(7) == 0);
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
